/* hw/rtl/rcfd_pkg.sv */
`timescale 1ns / 1ps

package rcfd_pkg;

    localparam int PAYLOAD_BYTES     = 22;
    localparam int PAYLOAD_W         = PAYLOAD_BYTES * 8;
    localparam int TYPE_POS          = 2;
    localparam int FIRST_PAYLOAD_POS = 3;
    localparam int LAST_PAYLOAD_POS  = FIRST_PAYLOAD_POS + PAYLOAD_BYTES - 1;
    localparam int STORE_IDX_W       = $clog2(PAYLOAD_BYTES);
    localparam int CHAN_W            = 11;

    localparam logic [7:0]  CRC_POLY        = 8'hD5;
    localparam logic [7:0]  CFG_TYPE_RESET  = 8'd22;
    localparam logic [7:0]  COUNT_MAX       = 8'd255;
    localparam logic [10:0] CHAN_MAX        = 11'h7FF;
    localparam logic [10:0] PULSE_BASE      = 11'd988;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_TOO_SHORT     = 3'd1,
        ST_CRC_BAD       = 3'd2,
        ST_OTHER_TYPE    = 3'd3,
        ST_PAYLOAD_SHORT = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  channel_index;
        logic [10:0] channel_value;
        logic [10:0] pulse_us;
        logic        last_result;
    } t_out_item;

    // One judged frame on its way from front to back
    typedef struct packed {
        t_status                status;
        logic [PAYLOAD_W-1:0]   payload;
    } t_job;

    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/rcfd_front.sv */
`timescale 1ns / 1ps

module rcfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rcfd_pkg::t_in_item i_item,
    input  logic [7:0]        i_cfg_type,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output rcfd_pkg::t_job    o_job
);
    import rcfd_pkg::*;

    logic [7:0] r_byte_count, n_byte_count;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_frame_type, n_frame_type;
    logic [7:0] r_store [PAYLOAD_BYTES];

    logic       w_accept;
    logic [7:0] w_pos;
    logic [7:0] w_byte;
    t_status    w_status;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_pos    = r_byte_count;
    assign w_byte   = i_item.data_byte;

    // Judge the frame in check order on its final byte
    always_comb begin
        if (w_pos < 8'(FIRST_PAYLOAD_POS)) begin
            w_status = ST_TOO_SHORT;
        end else if (r_crc != w_byte) begin
            w_status = ST_CRC_BAD;
        end else if (r_frame_type != i_cfg_type) begin
            w_status = ST_OTHER_TYPE;
        end else if (w_pos < 8'(LAST_PAYLOAD_POS + 1)) begin
            w_status = ST_PAYLOAD_SHORT;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_frame_type = r_frame_type;
        if (w_accept) begin
            if (i_item.last_byte) begin
                n_byte_count = '0;
                n_crc        = '0;
                n_frame_type = '0;
            end else begin
                if (w_pos == 8'(TYPE_POS)) begin
                    n_frame_type = w_byte;
                end
                if (w_pos >= 8'(TYPE_POS)) begin
                    n_crc = crc_fold(r_crc, w_byte);
                end
                if (r_byte_count != COUNT_MAX) begin
                    n_byte_count = r_byte_count + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_crc        <= '0;
            r_frame_type <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_frame_type <= n_frame_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !i_item.last_byte && w_pos >= 8'(FIRST_PAYLOAD_POS)
                && w_pos <= 8'(LAST_PAYLOAD_POS)) begin
            r_store[STORE_IDX_W'(w_pos - 8'(FIRST_PAYLOAD_POS))] <= w_byte;
        end
    end

    assign o_push = w_accept && i_item.last_byte;

    always_comb begin
        o_job.status = w_status;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            o_job.payload[8*i +: 8] = r_store[i];
        end
    end

endmodule

/* hw/rtl/rcfd_queue.sv */
`timescale 1ns / 1ps

module rcfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcfd_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output rcfd_pkg::t_job o_job
);
    import rcfd_pkg::*;

    t_job       r_entry [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_do_push, w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_valid   = (r_count != 2'd0);
    assign o_job     = r_entry[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* hw/rtl/rcfd_back.sv */
`timescale 1ns / 1ps

module rcfd_back #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rcfd_pkg::t_job      i_q_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output rcfd_pkg::t_out_item o_item
);
    import rcfd_pkg::*;

    localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

    t_job       r_job;
    logic       r_busy;
    logic [3:0] r_ch;
    logic       r_out_valid;
    t_out_item  r_out, w_res;

    logic        w_advance, w_fire, w_cur_last, w_done;
    logic [7:0]  w_bit_base;
    logic [10:0] w_value;

    assign w_advance  = !r_out_valid || i_ready;
    assign w_cur_last = (r_job.status != ST_OK) || (r_ch == LAST_CH);
    assign w_fire     = r_busy && w_advance;
    assign w_done     = w_fire && w_cur_last;
    assign o_pop      = i_q_valid && (!r_busy || w_done);

    // Channel k sits at payload bits 11k..11k+10, LSB first
    assign w_bit_base = {4'd0, r_ch} * 8'(CHAN_W);
    assign w_value    = r_job.payload[w_bit_base +: CHAN_W];

    always_comb begin
        w_res = '{status: r_job.status, channel_index: '0, channel_value: '0,
                  pulse_us: PULSE_BASE, last_result: 1'b1};
        if (r_job.status == ST_OK) begin
            w_res.channel_index = r_ch;
            w_res.channel_value = w_value;
            // v*1024/2047 is v/2, plus one only at full scale
            w_res.pulse_us = PULSE_BASE + {1'b0, w_value[10:1]}
                             + 11'(w_value == CHAN_MAX);
            w_res.last_result = (r_ch == LAST_CH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_ch   <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (w_fire) begin
                r_ch <= r_ch + 4'd1;
            end
            if (w_advance) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

/* hw/rtl/rc_channel_frame_decoder_core.sv */
`timescale 1ns / 1ps
// A frame's first result goes through the frame queue, job register and output register.
// One byte per cycle in while the frame queue has room; one result per cycle out
//   while output is taken; a good frame yields NUM_CHANNELS results, a bad one a single.
// The two-entry frame queue between decode and emit sets how far input runs ahead.
// Reset (synchronous, active low) clears counters, CRC, queue and output valid.
module rc_channel_frame_decoder_core #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rcfd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rcfd_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata
);
    import rcfd_pkg::*;

    // Frame type that marks a packed channel frame
    logic [7:0] r_cfg_type;

    logic w_push, w_q_full, w_q_valid, w_pop;
    t_job w_push_job, w_q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_type <= CFG_TYPE_RESET;
        end else if (i_cfg_we) begin
            r_cfg_type <= i_cfg_wdata;
        end
    end

    // Front: count bytes, run the CRC, hold the payload, judge on the final byte
    rcfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_item     (i_in_data),
        .i_cfg_type (r_cfg_type),
        .i_q_full   (w_q_full),
        .o_ready    (o_in_ready),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // Queue: each entry carries a status and a snapshot of the payload, so the
    // front may fill the next frame while the back still emits this one
    rcfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    // Back: unpack one channel per transfer into the output register, or one status result for a bad frame
    rcfd_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_job   (w_q_job),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("frame queue written while full");

    a_bad_frame_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
            (o_out_data.last_result && o_out_data.channel_value == '0
             && o_out_data.pulse_us == PULSE_BASE))
        else $error("status result not a single cleared result");

    a_next_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.status == ST_OK
         && !o_out_data.last_result) |=>
            (o_out_valid && o_out_data.status == ST_OK
             && o_out_data.channel_index == $past(o_out_data.channel_index) + 4'd1))
        else $error("channel burst broken");
`endif

endmodule
